FILE: rtl/blep_pkg.sv
// ----------------------------------------------------------------------------
// blep_pkg
// Shared types and constants of the binary Laplacian edge detector.
// ----------------------------------------------------------------------------
package blep_pkg;

  localparam int MAX_SIDE_DEF = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [7:0] THRESHOLD_RST    = 8'd127;
  localparam logic [8:0] FRAME_WIDTH_RST  = 9'd256;
  localparam logic [8:0] FRAME_HEIGHT_RST = 9'd256;

  localparam int LUMA_SUM_W = 18;
  localparam int LUMA_R     = 299;
  localparam int LUMA_G     = 587;
  localparam int LUMA_B     = 114;
  localparam int LUMA_DIV   = 1000;

  localparam logic [7:0] EDGE_ON  = 8'd255;
  localparam logic [7:0] EDGE_OFF = 8'd0;

  localparam int OUT_FIFO_DEPTH = 3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       flush;
  } blep_in_t;

  typedef struct packed {
    logic [7:0] edge_pixel;
    logic       last;
  } blep_out_t;

endpackage

FILE: rtl/blep_out_fifo.sv
// ----------------------------------------------------------------------------
// blep_out_fifo
// Small result queue between the filter stage and the result channel.
// ----------------------------------------------------------------------------
module blep_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  blep_pkg::blep_out_t push_data,
  input  logic                out_stall,
  output logic                out_valid,
  output blep_pkg::blep_out_t out_data,
  output logic [$clog2(blep_pkg::OUT_FIFO_DEPTH+1)-1:0] level
);

  localparam int DEPTH = blep_pkg::OUT_FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH+1);

  blep_pkg::blep_out_t slot_r [DEPTH];
  logic [PW-1:0] head_r;
  logic [PW-1:0] tail_r;
  logic [LW-1:0] level_r;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(DEPTH-1)) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign pop       = out_valid && !out_stall;
  assign out_valid = (level_r != '0);
  assign out_data  = slot_r[head_r];
  assign level     = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      level_r <= '0;
    end else begin
      if (push) begin
        tail_r <= ptr_inc(tail_r);
      end
      if (pop) begin
        head_r <= ptr_inc(head_r);
      end
      if (push && !pop) begin
        level_r <= level_r + LW'(1);
      end else if (pop && !push) begin
        level_r <= level_r - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= push_data;
    end
  end

endmodule

FILE: rtl/binary_laplacian_edge_detect.sv
// ----------------------------------------------------------------------------
// binary_laplacian_edge_detect
// RGB pixels in raster order are binarized on luma and run through a 3x3
// Laplacian; one edge flag per frame position comes out.
//
// Input channel (in_valid/in_stall/in_data): one pixel or flush per
// transaction. Result channel (out_valid/out_stall/out_data): edge_pixel is
// 255 for an edge and 0 otherwise; last marks the final position of a frame.
// The result for frame position p leaves on the transaction of item
// p + width + 1, so width + 1 flush items drain the frame tail. Flushes before
// the frame is complete are taken and dropped.
// Throughput: one item per clock while in_stall is low; the luma sum and the
// line store read are registered in the first stage, the line store write and
// the window update happen in the second. The line store is one memory of two
// bits per column. Reset restores threshold 127 and a 256x256 frame and starts
// a new frame; the line store needs no clearing. A stall on the result side
// fills a three-entry result queue, and in_stall rises before it overflows;
// nothing is lost. Configuration writes (cfg_ready is always high) are to go
// in only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module binary_laplacian_edge_detect #(
  parameter int MAX_SIDE = blep_pkg::MAX_SIDE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  blep_pkg::blep_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output blep_pkg::blep_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [blep_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [blep_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > blep_pkg::CFG_DATA_W) ? SW : blep_pkg::CFG_DATA_W;
  localparam int SUMW = blep_pkg::LUMA_SUM_W;
  localparam int LW = $clog2(blep_pkg::OUT_FIFO_DEPTH + 1);

  logic [7:0] threshold_r;
  logic [8:0] frame_width_r;
  logic [8:0] frame_height_r;

  logic [CW-1:0] w_ext;
  logic [CW-1:0] h_ext;
  logic [CW-1:0] w_clamp;
  logic [CW-1:0] h_clamp;
  logic [SW-1:0] w_side;
  logic [SW-1:0] h_side;

  logic          post_r;
  logic [AW-1:0] row_r;
  logic [AW-1:0] col_r;
  logic [SW-1:0] tail_cnt_r;

  logic          cfg_wr;
  logic          in_accept;
  logic          pix;
  logic          col_end;
  logic          row_end;
  logic          tail_end;
  logic          emit;

  logic            s1_valid_r;
  logic            s1_pix_r;
  logic            s1_emit_r;
  logic            s1_last_r;
  logic            s1_inner_r;
  logic [AW-1:0]   s1_col_r;
  logic [SUMW-1:0] s1_sum_r;
  logic [1:0]      rd_r;

  logic [1:0]      line_mem [MAX_SIDE];
  logic [5:0]      win_r;

  logic [SUMW-1:0] luma_sum;
  logic [SUMW-1:0] luma_limit;
  logic            new_bit;
  logic [2:0]      new_col;
  logic            edge_hit;
  logic            push;
  blep_pkg::blep_out_t push_data;
  logic [LW-1:0]   level;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = ((LW+1)'(level) + (LW+1)'(s1_valid_r)) >=
                     (LW+1)'(blep_pkg::OUT_FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= blep_pkg::THRESHOLD_RST;
      frame_width_r  <= blep_pkg::FRAME_WIDTH_RST;
      frame_height_r <= blep_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        blep_pkg::REG_THRESHOLD:    threshold_r    <= cfg_data[7:0];
        blep_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        blep_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_ext   = CW'(frame_width_r);
  assign h_ext   = CW'(frame_height_r);
  assign w_clamp = (w_ext < CW'(3)) ? CW'(3) :
                   (w_ext > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : w_ext;
  assign h_clamp = (h_ext < CW'(3)) ? CW'(3) :
                   (h_ext > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : h_ext;
  assign w_side  = SW'(w_clamp);
  assign h_side  = SW'(h_clamp);

  assign pix      = !post_r && !in_data.flush;
  assign col_end  = SW'(col_r) == (w_side - SW'(1));
  assign row_end  = SW'(row_r) == (h_side - SW'(1));
  assign tail_end = tail_cnt_r == w_side;
  assign emit     = post_r ||
                    (pix && ((row_r >= AW'(2)) || ((row_r == AW'(1)) && (col_r != '0))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_r     <= 1'b0;
      row_r      <= '0;
      col_r      <= '0;
      tail_cnt_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
      if (cfg_wr && ((cfg_index == blep_pkg::REG_FRAME_WIDTH) ||
                     (cfg_index == blep_pkg::REG_FRAME_HEIGHT))) begin
        post_r     <= 1'b0;
        row_r      <= '0;
        col_r      <= '0;
        tail_cnt_r <= '0;
      end else if (in_accept) begin
        if (post_r) begin
          if (tail_end) begin
            post_r     <= 1'b0;
            row_r      <= '0;
            col_r      <= '0;
            tail_cnt_r <= '0;
          end else begin
            tail_cnt_r <= tail_cnt_r + SW'(1);
          end
        end else if (!in_data.flush) begin
          if (col_end) begin
            col_r <= '0;
            if (row_end) begin
              post_r     <= 1'b1;
              tail_cnt_r <= '0;
            end else begin
              row_r <= row_r + AW'(1);
            end
          end else begin
            col_r <= col_r + AW'(1);
          end
        end
      end
    end
  end

  assign luma_sum = SUMW'(blep_pkg::LUMA_R) * SUMW'(in_data.red) +
                    SUMW'(blep_pkg::LUMA_G) * SUMW'(in_data.green) +
                    SUMW'(blep_pkg::LUMA_B) * SUMW'(in_data.blue);

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r   <= pix;
      s1_emit_r  <= emit;
      s1_last_r  <= post_r && tail_end;
      s1_inner_r <= pix && (row_r >= AW'(2)) && (col_r >= AW'(2));
      s1_col_r   <= col_r;
      s1_sum_r   <= luma_sum;
    end
  end

  // bit 0: two rows up, bit 1: one row up
  always_ff @(posedge clk) begin
    if (in_accept && pix) begin
      rd_r <= line_mem[col_r];
    end
    if (s1_valid_r && s1_pix_r) begin
      line_mem[s1_col_r] <= {new_bit, rd_r[1]};
    end
  end

  assign luma_limit = SUMW'(blep_pkg::LUMA_DIV) * (SUMW'(threshold_r) + SUMW'(1));
  assign new_bit    = s1_sum_r >= luma_limit;
  assign new_col    = {new_bit, rd_r[1], rd_r[0]};
  assign edge_hit   = s1_inner_r && win_r[1] &&
                      !(&{win_r[5:3], new_col, win_r[0], win_r[2]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_valid_r && s1_pix_r) begin
      win_r <= {win_r[2:0], new_col};
    end
  end

  assign push                 = s1_valid_r && s1_emit_r;
  assign push_data.edge_pixel = edge_hit ? blep_pkg::EDGE_ON : blep_pkg::EDGE_OFF;
  assign push_data.last       = s1_last_r;

  blep_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .level     (level)
  );

  a_line_store_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && pix && s1_valid_r && s1_pix_r) |-> (col_r != s1_col_r))
    else $error("line store read and write hit the same column");

  a_last_is_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> (out_data.edge_pixel == blep_pkg::EDGE_OFF))
    else $error("final frame position reported as edge");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && post_r && tail_end) |=> (!post_r && (row_r == '0) && (col_r == '0)))
    else $error("frame did not restart after final result");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !(out_valid && !out_stall)) |->
    (level < LW'(blep_pkg::OUT_FIFO_DEPTH)))
    else $error("result queue overflow");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks binary_laplacian_edge_detect end to end. Pixel and flush
// transactions go in under several frame sizes and thresholds. Each accepted
// transaction is run through a cycle-free edge predictor, and every result
// transaction is compared field by field with the oldest pending prediction.
// A short table of directed transactions runs first. Random frame settings
// follow, mostly with well-formed frames, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE_LIMIT  = blep_pkg::MAX_SIDE_DEF;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 620;
  localparam int PART_EXTRA  = 40;
  localparam int Y_RED       = 299;
  localparam int Y_GREEN     = 587;
  localparam int Y_BLUE      = 114;
  localparam int Y_SCALE     = 1000;

  localparam logic [blep_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [7:0] PIX_WHITE = 8'd255;
  localparam logic [7:0] PIX_BLACK = 8'd0;

  typedef struct packed {
    blep_pkg::blep_in_t  px;
    bit                  resize;
    bit                  typed;
    blep_pkg::blep_out_t want;
  } dir_row_t;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  blep_pkg::blep_in_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  blep_pkg::blep_out_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [blep_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [blep_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  binary_laplacian_edge_detect u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  cur_threshold;
  logic [8:0]  cur_width_raw;
  logic [8:0]  cur_height_raw;
  bit          row_two_up [SIDE_LIMIT];
  bit          row_one_up [SIDE_LIMIT];
  logic [5:0]  win_bits;
  int unsigned pos_count;

  blep_pkg::blep_out_t pending_edges [$];
  int          err_count   = 0;
  int          tx_idle_pct = 16;
  int          rx_idle_pct = 51;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  function automatic int unsigned side_used(input logic [8:0] v);
    if (v < 9'd3) return 3;
    if (v > SIDE_LIMIT) return SIDE_LIMIT;
    return 32'(v);
  endfunction

  task automatic model_reset();
    cur_threshold  = blep_pkg::THRESHOLD_RST;
    cur_width_raw  = blep_pkg::FRAME_WIDTH_RST;
    cur_height_raw = blep_pkg::FRAME_HEIGHT_RST;
    foreach (row_two_up[i]) begin
      row_two_up[i] = 1'b0;
      row_one_up[i] = 1'b0;
    end
    win_bits  = '0;
    pos_count = 0;
  endtask

  task automatic predict_edge(input blep_pkg::blep_in_t px, output bit counted,
                              output bit produced, output blep_pkg::blep_out_t res);
    int unsigned w, h, total, n, luma, row, c, col, p, nbrs;
    bit          newbit, upbit, midbit;
    logic [2:0]  newcol, prev, older;
    int          acc;
    logic [7:0]  edge_val;
    w        = side_used(cur_width_raw);
    h        = side_used(cur_height_raw);
    total    = w * h;
    n        = pos_count;
    counted  = 1'b1;
    produced = 1'b0;
    res      = '0;
    edge_val = PIX_BLACK;
    if (n < total) begin
      if (px.flush) begin
        counted = 1'b0;
        return;
      end
      luma   = (Y_RED * int'(px.red) + Y_GREEN * int'(px.green) + Y_BLUE * int'(px.blue))
               / Y_SCALE;
      newbit = (luma > cur_threshold);
      row    = n / w;
      c      = n % w;
      col    = c % SIDE_LIMIT;
      upbit  = row_two_up[col];
      midbit = row_one_up[col];
      newcol = {newbit, midbit, upbit};
      if (row >= 2 && c >= 2) begin
        prev  = win_bits[2:0];
        older = win_bits[5:3];
        nbrs  = $countones({older, newcol, prev[2], prev[0]});
        acc   = 8 * (prev[1] ? 255 : 0) - int'(nbrs) * 255;
        if (acc / 8 > 0) edge_val = PIX_WHITE;
      end
      row_two_up[col] = midbit;
      row_one_up[col] = newbit;
      win_bits        = {win_bits[2:0], newcol};
    end
    pos_count = n + 1;
    if (n < w + 1) return;
    p              = n - (w + 1);
    produced       = 1'b1;
    res.edge_pixel = edge_val;
    res.last       = (p + 1 == total);
    if (p + 1 >= total) pos_count = 0;
  endtask

  function automatic blep_pkg::blep_in_t rand_px(input bit fl);
    blep_pkg::blep_in_t px;
    logic [7:0]         grey;
    grey = cur_threshold + 8'($urandom_range(0, 2)) - 8'd1;
    if ($urandom_range(3) == 0) begin
      px.red   = grey;
      px.green = grey;
      px.blue  = grey;
    end else begin
      px.red   = 8'($urandom_range(0, 255));
      px.green = 8'($urandom_range(0, 255));
      px.blue  = 8'($urandom_range(0, 255));
    end
    px.flush = fl;
    return px;
  endfunction

  function automatic dir_row_t dir_row(input logic [7:0] r, g, b, input bit fl, resize,
                                       typed, input logic [7:0] e, input bit l);
    dir_row_t d;
    d.px.red          = r;
    d.px.green        = g;
    d.px.blue         = b;
    d.px.flush        = fl;
    d.resize          = resize;
    d.typed           = typed;
    d.want.edge_pixel = e;
    d.want.last       = l;
    return d;
  endfunction

  task automatic send_item(input blep_pkg::blep_in_t px, input bit use_want,
                           input blep_pkg::blep_out_t want, output bit counted);
    bit                  produced;
    blep_pkg::blep_out_t res;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    predict_edge(px, counted, produced, res);
    if (produced) pending_edges.push_back(use_want ? want : res);
  endtask

  task automatic send_frame(input int unsigned pixels, input int unsigned drain,
                            inout int unsigned tally);
    bit counted;
    for (int unsigned i = 0; i < pixels; i++) begin
      if ($urandom_range(99) < 8) begin
        send_item(rand_px(1'b1), 1'b0, '0, counted);
        tally += counted;
      end
      send_item(rand_px(1'b0), 1'b0, '0, counted);
      tally += counted;
    end
    for (int unsigned i = 0; i < drain; i++) begin
      send_item(rand_px(1'($urandom_range(1))), 1'b0, '0, counted);
      tally += counted;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [blep_pkg::CFG_IDX_W-1:0] idx,
                           input logic [blep_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      blep_pkg::REG_THRESHOLD: begin
        cur_threshold = val[7:0];
      end
      blep_pkg::REG_FRAME_WIDTH: begin
        cur_width_raw = val;
        pos_count     = 0;
      end
      blep_pkg::REG_FRAME_HEIGHT: begin
        cur_height_raw = val;
        pos_count      = 0;
      end
      default: ;
    endcase
  endtask

  task automatic write_settings(input bit thr_en, input logic [8:0] thr, input bit size_en,
                                input logic [8:0] w, h, input bit junk);
    if (thr_en) cfg_write(blep_pkg::REG_THRESHOLD, thr);
    if (size_en) begin
      cfg_write(blep_pkg::REG_FRAME_WIDTH, w);
      cfg_write(blep_pkg::REG_FRAME_HEIGHT, h);
    end
    if (junk) cfg_write(REG_UNUSED, 9'($urandom_range(0, 511)));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    blep_pkg::blep_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_edges.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual edge_pixel %0d last %0d",
                 $time, out_data.edge_pixel, out_data.last);
      end else begin
        want = pending_edges.pop_front();
        if (out_data.edge_pixel !== want.edge_pixel) begin
          err_count++;
          $display("%0t: edge_pixel mismatch, expected %0d, actual %0d",
                   $time, want.edge_pixel, out_data.edge_pixel);
        end
        if (out_data.last !== want.last) begin
          err_count++;
          $display("%0t: last mismatch, expected %0d, actual %0d",
                   $time, want.last, out_data.last);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t    rows [$];
    bit          counted;
    bit          big, size_en, junk, quiet_hold;
    logic [8:0]  thr, w, h;
    int unsigned rand_items, phase_items, nframes, w_use, total, kind, spins;
    int          phase;
    model_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset frame is 256x256: flush dropped, one pixel taken, nothing out
    rows.push_back(dir_row(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, PIX_BLACK, 1'b0));
    // 3x3 frame, width written below range, reset threshold
    rows.push_back(dir_row(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'h7F, 8'h7F, 8'h7F, 1'b0, 1'b0, 1'b0, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'h80, 8'h80, 8'h80, 1'b0, 1'b0, 1'b1, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b1, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'h7F, 8'h7F, 8'h7F, 1'b0, 1'b0, 1'b1, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, PIX_BLACK, 1'b0));
    // drain: pixels after frame end act as flushes
    rows.push_back(dir_row(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b1, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b1, PIX_BLACK, 1'b0));
    rows.push_back(dir_row(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, PIX_BLACK, 1'b1));

    foreach (rows[i]) begin
      if (rows[i].resize) begin
        wait_idle();
        write_settings(1'b0, '0, 1'b1, 9'd1, 9'd3, 1'b1);
      end
      send_item(rows[i].px, rows[i].typed, rows[i].want, counted);
    end
    wait_idle();

    rand_items = 0;
    phase      = 0;
    quiet_hold = 1'b0;
    while (rand_items < RAND_ITEMS) begin
      if (rand_items < RAND_ITEMS / 3) begin
        tx_idle_pct = 16;
        rx_idle_pct <= 51;
      end else if (rand_items < 2 * RAND_ITEMS / 3) begin
        tx_idle_pct = 51;
        rx_idle_pct <= 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      big     = 1'b0;
      nframes = $urandom_range(1, 3);
      thr     = 9'($urandom_range(0, 511));
      size_en = ($urandom_range(99) < 70);
      junk    = ($urandom_range(99) < 25);
      w       = 9'($urandom_range(3, 10));
      h       = 9'($urandom_range(3, 8));
      if ($urandom_range(9) == 0) w = 9'($urandom_range(0, 2));
      if ($urandom_range(9) == 0) h = 9'($urandom_range(0, 2));
      case (phase)
        0: begin
          thr     = 9'd0;
          size_en = 1'b1;
        end
        1: begin
          w       = 9'd300;
          h       = 9'd511;
          size_en = 1'b1;
          big     = 1'b1;
          nframes = 1;
        end
        2: begin
          thr     = 9'h0FF;
          size_en = 1'b1;
        end
        3: begin
          w       = 9'($urandom_range(0, 2));
          h       = 9'($urandom_range(0, 2));
          size_en = 1'b1;
        end
        default: ;
      endcase
      write_settings(1'b1, thr, size_en, w, h, junk);
      if (phase == 4 || (tx_idle_pct == 0 && !quiet_hold)) begin
        hold_req <= hold_req + 1;
        if (tx_idle_pct == 0) quiet_hold = 1'b1;
      end
      phase_items = 0;
      for (int unsigned f = 0; f < nframes; f++) begin
        w_use = side_used(cur_width_raw);
        total = w_use * side_used(cur_height_raw);
        kind  = $urandom_range(99);
        if (big) begin
          send_frame(w_use + PART_EXTRA, 0, phase_items);
        end else if (kind < 80) begin
          send_frame(total, w_use + 1, phase_items);
        end else if (kind < 90) begin
          send_frame(total, $urandom_range(0, w_use), phase_items);
        end else begin
          repeat ($urandom_range(5, 30)) begin
            send_item(rand_px(1'($urandom_range(1))), 1'b0, '0, counted);
            phase_items += counted;
          end
        end
      end
      wait_idle();
      rand_items += phase_items;
      phase++;
    end

    in_valid <= 1'b0;
    spins = 0;
    while (pending_edges.size() != 0 && spins < 200000) begin
      @(posedge clk);
      spins++;
    end
    repeat (2 * SETTLE) @(posedge clk);
    if (pending_edges.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_edges.size());
    end
    if (err_count == 0 && pending_edges.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/blep_pkg.sv
rtl/blep_out_fifo.sv
rtl/binary_laplacian_edge_detect.sv
sim/testbench.sv
